[design/segment_linear_resampler_unit_macros.svh]
// Assertion macros for the segment linear resampler.
// Included by the modules that carry concurrent checks; no other dependency.
`ifndef SEGMENT_LINEAR_RESAMPLER_UNIT_MACROS_SVH
`define SEGMENT_LINEAR_RESAMPLER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SLR_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slr: same-cycle check failed");
`define SLR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slr: next-cycle check failed");
`else
`define SLR_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SLR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[design/slr_pkg.sv]
// Shared types and constants of the segment linear resampler.
// No dependencies; used by the controller, datapath and top level.
package slr_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 7;
  localparam logic [CFG_W-1:0] TARGET_LENGTH_RESET = 7'd64;

  // controller -> datapath
  typedef struct packed {
    logic load;      // word accepted on the input
    logic seg_end;   // accepted word closes the segment
    logic div_step;  // one quotient bit
    logic addr;      // compute read addresses and issue reads
    logic mul;       // weight the neighbour difference
    logic out_load;  // finish the result into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic k_last;
    logic out_free;
  } status_t;

endpackage

[design/slr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module slr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/slr_datapath.sv]
// Datapath: sample store, step divider, position walk, interpolation, output register.
// Depends on slr_pkg, slr_ram and the assertion macro header.
`include "segment_linear_resampler_unit_macros.svh"
module slr_datapath #(
  parameter int MAX_SEGMENT = 64,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  slr_pkg::cmd_t                 cmd,
  output slr_pkg::status_t              status,
  input  logic [slr_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                          cfg_we,
  input  logic [slr_pkg::CFG_W-1:0]     cfg_wdata,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [slr_pkg::SAMPLE_W-1:0]  out_sample,
  output logic                          out_last,
  output logic                          out_drop
);
  import slr_pkg::*;

  localparam int IDX_W  = $clog2(MAX_SEGMENT);
  localparam int CNT_W  = $clog2(MAX_SEGMENT + 1);
  localparam int QW     = IDX_W + FRAC_BITS;
  localparam int DC_W   = $clog2(QW + 1);
  localparam int PROD_W = SAMPLE_W + FRAC_BITS;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SEGMENT);
  localparam logic [CFG_W-1:0] MAX_LEN = CFG_W'(MAX_SEGMENT);
  localparam logic [CFG_W-1:0] MIN_LEN = CFG_W'(2);

  logic [CFG_W-1:0]  target_length;
  logic [CNT_W-1:0]  loaded_count;
  logic              dropped_flag;
  logic [IDX_W-1:0]  seg_last;     // stored length - 1
  logic              seg_drop;
  logic [IDX_W-1:0]  new_last;     // output length - 1, also the divisor
  logic [IDX_W-1:0]  div_rem;
  logic [QW-1:0]     div_quo;      // dividend shifts out, step shifts in
  logic [DC_W-1:0]   div_cnt;
  logic [QW-1:0]     pos;
  logic [IDX_W-1:0]  k;
  logic [FRAC_BITS-1:0] frac_r;
  logic signed [SAMPLE_W-1:0] y1_r;
  logic              neg_r;
  logic [PROD_W-1:0] prod_r;

  // load side
  logic              has_room;
  logic [CNT_W-1:0]  len_next;
  logic              drop_next;
  logic [CFG_W-1:0]  len_clamped;

  assign has_room  = (loaded_count != MAX_CNT);
  assign len_next  = loaded_count + CNT_W'(has_room);
  assign drop_next = dropped_flag | ~has_room;

  always_comb begin
    if (target_length < MIN_LEN) begin
      len_clamped = MIN_LEN;
    end else if (target_length > MAX_LEN) begin
      len_clamped = MAX_LEN;
    end else begin
      len_clamped = target_length;
    end
  end

  // divider step
  logic [IDX_W:0] rem_sh;
  logic           q_bit;
  assign rem_sh = {div_rem, div_quo[QW-1]};
  assign q_bit  = (rem_sh >= {1'b0, new_last});

  // address stage
  logic [QW-1:0]        pos_sum;
  logic [IDX_W-1:0]     pos_int;
  logic [IDX_W-1:0]     rd_a0;
  logic [IDX_W-1:0]     rd_a1;
  logic [FRAC_BITS-1:0] frac_sel;
  logic                 is_first;

  assign pos_sum  = pos + div_quo;
  assign pos_int  = pos_sum[QW-1:FRAC_BITS];
  assign is_first = (k == '0);

  always_comb begin
    if (is_first) begin
      rd_a0    = '0;
      frac_sel = '0;
    end else if (status.k_last) begin
      rd_a0    = seg_last;
      frac_sel = '0;
    end else begin
      rd_a0    = (pos_int > seg_last) ? seg_last : pos_int;
      frac_sel = pos_sum[FRAC_BITS-1:0];
    end
    rd_a1 = (rd_a0 == seg_last) ? rd_a0 : rd_a0 + IDX_W'(1);
  end

  logic [SAMPLE_W-1:0] rd0_data;
  logic [SAMPLE_W-1:0] rd1_data;

  // two copies of the store give both neighbours in one read
  slr_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_SEGMENT)) u_store_lo (
    .clk     (clk),
    .wr_en   (cmd.load && has_room),
    .wr_addr (loaded_count[IDX_W-1:0]),
    .wr_data (in_sample),
    .rd_en   (cmd.addr),
    .rd_addr (rd_a0),
    .rd_data (rd0_data)
  );

  slr_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_SEGMENT)) u_store_hi (
    .clk     (clk),
    .wr_en   (cmd.load && has_room),
    .wr_addr (loaded_count[IDX_W-1:0]),
    .wr_data (in_sample),
    .rd_en   (cmd.addr),
    .rd_addr (rd_a1),
    .rd_data (rd1_data)
  );

  // weighting stage
  logic signed [SAMPLE_W:0] diff;
  logic signed [SAMPLE_W:0] diff_abs;
  logic [SAMPLE_W-1:0]      mag;
  assign diff     = $signed({rd1_data[SAMPLE_W-1], rd1_data})
                  - $signed({rd0_data[SAMPLE_W-1], rd0_data});
  assign diff_abs = diff[SAMPLE_W] ? -diff : diff;
  assign mag      = diff_abs[SAMPLE_W-1:0];

  // final add; the weighted part truncates toward zero
  logic [SAMPLE_W-1:0]      q_mag;
  logic signed [SAMPLE_W:0] part;
  logic signed [SAMPLE_W:0] res;
  assign q_mag = prod_r[PROD_W-1:FRAC_BITS];
  assign part  = neg_r ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
  assign res   = $signed({y1_r[SAMPLE_W-1], y1_r}) + part;

  assign status.div_done = (div_cnt == '0);
  assign status.k_last   = (k == new_last);
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_length <= TARGET_LENGTH_RESET;
      loaded_count  <= '0;
      dropped_flag  <= 1'b0;
      div_cnt       <= '0;
      k             <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        target_length <= cfg_wdata;
      end
      if (cmd.load) begin
        if (cmd.seg_end) begin
          loaded_count <= '0;
          dropped_flag <= 1'b0;
          div_cnt      <= DC_W'(QW);
          k            <= '0;
        end else begin
          loaded_count <= len_next;
          dropped_flag <= drop_next;
        end
      end
      if (cmd.div_step) begin
        div_cnt <= div_cnt - DC_W'(1);
      end
      if (cmd.out_load) begin
        k         <= k + IDX_W'(1);
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seg_end) begin
      seg_last <= IDX_W'(len_next - CNT_W'(1));
      seg_drop <= drop_next;
      new_last <= IDX_W'(len_clamped - CFG_W'(1));
      div_rem  <= '0;
      div_quo  <= {IDX_W'(len_next - CNT_W'(1)), {FRAC_BITS{1'b0}}};
      pos      <= '0;
    end
    if (cmd.div_step) begin
      div_rem <= q_bit ? IDX_W'(rem_sh - {1'b0, new_last}) : IDX_W'(rem_sh);
      div_quo <= {div_quo[QW-2:0], q_bit};
    end
    if (cmd.addr) begin
      frac_r <= frac_sel;
      if (!is_first && !status.k_last) begin
        pos <= pos_sum;
      end
    end
    if (cmd.mul) begin
      y1_r   <= $signed(rd0_data);
      neg_r  <= diff[SAMPLE_W];
      prod_r <= PROD_W'(mag) * PROD_W'(frac_r);
    end
    if (cmd.out_load) begin
      out_sample <= res[SAMPLE_W-1:0];
      out_last   <= status.k_last;
      out_drop   <= seg_drop;
    end
  end

  `SLR_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, loaded_count <= MAX_CNT)
  `SLR_ASSERT_IMPL(a_out_load_free, clk, rst, cmd.out_load, !out_valid || out_ready)
  `SLR_ASSERT_IMPL(a_rd_order, clk, rst, cmd.addr, (rd_a1 >= rd_a0) && (rd_a1 <= seg_last))
  `SLR_ASSERT_NEXT(a_final_word, clk, rst, cmd.out_load && status.k_last, out_valid && out_last)

endmodule

[design/slr_ctrl.sv]
// Controller state machine: load, divide, then address/weight/emit per output word.
// Depends on slr_pkg.
module slr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tlast,
  output logic              s_tready,
  output slr_pkg::cmd_t     cmd,
  input  slr_pkg::status_t  status
);
  import slr_pkg::*;

  typedef enum logic [4:0] {
    S_LOAD = 5'b00001,
    S_DIV  = 5'b00010,
    S_ADDR = 5'b00100,
    S_MUL  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == S_LOAD);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_LOAD: begin
        cmd.load    = s_tvalid;
        cmd.seg_end = s_tvalid && s_tlast;
        if (s_tvalid && s_tlast) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (status.div_done) begin
          state_next = S_ADDR;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_ADDR: begin
        cmd.addr   = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = status.k_last ? S_LOAD : S_ADDR;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule

[design/segment_linear_resampler_unit.sv]
// Channel   | Dir | Payload
// s_*       | in  | tdata[15:0] = sample, tlast = last_sample
// m_*       | out | tdata[15:0] = scaled_sample, tlast = last_output, tuser = overflow
// cfg_*     | in  | cfg_wdata = target_length, written when cfg_we is high
//
// Input words load one per cycle. After the closing word the step divider produces
// one quotient bit per cycle, IDX_W + FRAC_BITS bits in all, then sees itself done;
// each output word then passes address and store read, multiply and final add.
// Input is not taken from the closing word until the final output word sits in
// the output register; a stalled output holds the sequencer in its emit step.
// Reset is synchronous; the sample store needs no clearing.
// Top level of the segment linear resampler; depends on slr_pkg, slr_ctrl, slr_datapath.
module segment_linear_resampler_unit #(
  parameter int MAX_SEGMENT = 64,
  parameter int FRAC_BITS   = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [slr_pkg::SAMPLE_W-1:0] s_tdata,   // [15:0] sample
  input  logic                         s_tlast,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [slr_pkg::SAMPLE_W-1:0] m_tdata,   // [15:0] scaled_sample
  output logic                         m_tlast,
  output logic                         m_tuser,   // [0] overflow
  input  logic                         cfg_we,
  input  logic [slr_pkg::CFG_W-1:0]    cfg_wdata
);
  import slr_pkg::*;

  cmd_t    cmd;
  status_t status;

  slr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .cmd      (cmd),
    .status   (status)
  );

  slr_datapath #(
    .MAX_SEGMENT (MAX_SEGMENT),
    .FRAC_BITS   (FRAC_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .in_sample  (s_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_sample (m_tdata),
    .out_last   (m_tlast),
    .out_drop   (m_tuser)
  );

endmodule

[tb/sv/tb_segment_linear_resampler_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for segment_linear_resampler_unit: directed and random segments,
// an interpolation predictor of its own and an in-order scoreboard of resampled words.
// Depends on slr_pkg and the segment_linear_resampler_unit RTL.
module tb_segment_linear_resampler_unit;
  import slr_pkg::*;

  localparam int MAX_SEG       = 64;
  localparam int SEG_AW        = $clog2(MAX_SEG);
  localparam int FRAC          = 16;
  localparam int STALL_LIMIT   = 4000;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_REPORTS   = 10;
  localparam int PHASE_ITEMS   = 20;

  typedef struct packed {
    logic [SAMPLE_W-1:0] smp;
    logic                lst;
  } sample_word_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                lst;
    logic                ovf;
  } resampled_word_t;

  typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [SAMPLE_W-1:0] s_tdata   = '0;   // [15:0] sample
  logic                s_tlast   = 1'b0;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [SAMPLE_W-1:0] m_tdata;          // [15:0] scaled_sample
  logic                m_tlast;
  logic                m_tuser;          // [0] overflow
  logic                cfg_we    = 1'b0;
  logic [CFG_W-1:0]    cfg_wdata = '0;

  segment_linear_resampler_unit #(
    .MAX_SEGMENT(MAX_SEG),
    .FRAC_BITS  (FRAC)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // pending input words and expected resampled words
  sample_word_t    sample_queue[$];
  resampled_word_t resampled_q[$];

  // predictor state
  logic [SAMPLE_W-1:0] seg_mem [MAX_SEG];
  logic [6:0]          seg_fill   = '0;
  logic                seg_lost   = 1'b0;
  logic [CFG_W-1:0]    length_reg = TARGET_LENGTH_RESET;

  int unsigned error_count  = 0;
  int unsigned stall_cycles = 0;
  int unsigned hold_request = 0;

  // Store one sample; on the closing word, queue the whole resampled segment.
  function automatic void absorb_sample(input logic [SAMPLE_W-1:0] smp, input logic lst);
    int unsigned     out_len;
    int unsigned     k;
    int unsigned     i0;
    int unsigned     i1;
    logic [22:0]     step_q;
    logic [22:0]     pos_q;
    logic signed [16:0] y1;
    logic signed [16:0] y2;
    logic signed [16:0] diff;
    logic signed [16:0] part;
    logic [16:0]     mag;
    logic [32:0]     prod;
    resampled_word_t w;
    if (seg_fill < MAX_SEG) begin
      seg_mem[SEG_AW'(seg_fill)] = smp;
      seg_fill++;
    end else begin
      seg_lost = 1'b1;
    end
    if (!lst) return;
    out_len = 32'(length_reg);
    if (out_len < 2) out_len = 2;
    if (out_len > MAX_SEG) out_len = MAX_SEG;
    step_q = (23'(seg_fill - 1) << FRAC) / 23'(out_len - 1);
    pos_q  = '0;
    for (k = 0; k < out_len; k++) begin
      if (k == 0) begin
        w.value = seg_mem[0];
      end else if (k == out_len - 1) begin
        w.value = seg_mem[SEG_AW'(seg_fill - 1)];
      end else begin
        pos_q = pos_q + step_q;
        i0 = 32'(pos_q >> FRAC);
        if (i0 > seg_fill - 1) i0 = seg_fill - 1;
        i1 = i0 + 1;
        if (i1 > seg_fill - 1) i1 = seg_fill - 1;
        y1   = 17'($signed(seg_mem[SEG_AW'(i0)]));
        y2   = 17'($signed(seg_mem[SEG_AW'(i1)]));
        diff = y2 - y1;
        mag  = (diff < 0) ? 17'(-diff) : 17'(diff);
        prod = 33'(mag) * 33'(pos_q[FRAC-1:0]);
        // weighted difference truncates toward zero
        part = (diff < 0) ? -$signed(prod[32:16]) : $signed(prod[32:16]);
        w.value = 16'(y1 + part);
      end
      w.lst = (k == out_len - 1);
      w.ovf = seg_lost;
      resampled_q.push_back(w);
    end
    seg_fill = '0;
    seg_lost = 1'b0;
  endfunction

  // input side observer: config writes and accepted words feed the predictor
  always @(posedge clk) begin
    if (rst) begin
      seg_fill   = '0;
      seg_lost   = 1'b0;
      length_reg = TARGET_LENGTH_RESET;
    end else begin
      if (cfg_we) length_reg = cfg_wdata;
      if (s_tvalid && s_tready) absorb_sample(s_tdata, s_tlast);
    end
  end

  // driver: bursts of random length with random gaps
  int unsigned  burst_left = 1;
  int unsigned  gap_left   = 0;
  sample_word_t next_word;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid   <= 1'b0;
      s_tdata    <= '0;
      s_tlast    <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (sample_queue.size() > 0) begin
        next_word = sample_queue.pop_front();
        s_tdata  <= next_word.smp;
        s_tlast  <= next_word.lst;
        s_tvalid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern switches among open, mostly ready, sparse and periodic modes
  rx_mode_t    rx_mode   = RX_OPEN;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  int unsigned rx_tick   = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      mode_left = 0;
      hold_left = 0;
    end else begin
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(64, 256);
      end else begin
        mode_left--;
      end
      rx_tick++;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:     m_tready <= 1'b1;
          RX_MOSTLY:   m_tready <= ($urandom_range(0, 3) != 0);
          RX_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
          RX_PERIODIC: m_tready <= ((rx_tick % 8) < 5);
        endcase
      end
    end
  end

  // monitor and scoreboard
  resampled_word_t want;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (resampled_q.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: unexpected word: data %h last %b overflow %b",
                   $time, m_tdata, m_tlast, m_tuser);
      end else begin
        want = resampled_q.pop_front();
        if (m_tdata !== want.value || m_tlast !== want.lst || m_tuser !== want.ovf) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: mismatch: data exp %h got %h, last exp %b got %b, ovf exp %b got %b",
                     $time, want.value, m_tdata, want.lst, m_tlast, want.ovf, m_tuser);
        end
      end
    end
  end

  // watchdog: cycles with work outstanding but no handshake
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles = 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                 (sample_queue.size() == 0 && !s_tvalid && resampled_q.size() == 0)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic push_word(input logic [SAMPLE_W-1:0] smp, input logic lst);
    sample_word_t w;
    w.smp = smp;
    w.lst = lst;
    sample_queue.push_back(w);
  endtask

  // random segment of n words, extremes mixed in
  task automatic push_segment(input int unsigned n);
    int unsigned         i;
    logic [SAMPLE_W-1:0] v;
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 15))
        0:       v = 16'h7FFF;
        1:       v = 16'h8000;
        2:       v = 16'h0000;
        default: v = 16'($urandom);
      endcase
      push_word(v, i == n - 1);
    end
  endtask

  // wait until the block has nothing left to deliver, then let it settle
  task automatic drain();
    while (sample_queue.size() > 0 || s_tvalid || resampled_q.size() > 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_length(input logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_phase(input int unsigned items, input bit with_overflow);
    int unsigned count;
    int unsigned n;
    count = 0;
    if (with_overflow) begin
      n = MAX_SEG + $urandom_range(1, 6);
      push_segment(n);
      count += n;
    end
    while (count < items) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, MAX_SEG) : $urandom_range(1, 12);
      push_segment(n);
      count += n;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset length, one-sample segment and full-scale swings
    push_word(16'h8000, 1'b1);
    push_word(16'h7FFF, 1'b0);
    push_word(16'h8000, 1'b1);
    push_word(16'h8000, 1'b0);
    push_word(16'h7FFF, 1'b0);
    push_word(16'h0001, 1'b1);
    drain();
    write_length(7'd2);
    push_word(16'hFFFF, 1'b0);
    push_word(16'h7FFF, 1'b0);
    push_word(16'h8000, 1'b0);
    push_word(16'h1234, 1'b0);
    push_word(16'h8000, 1'b1);
    drain();
    // below range clamps to 2
    write_length(7'd0);
    push_segment(3);
    drain();
    // above range clamps to the store depth
    write_length(7'd127);
    push_segment(4);
    drain();
    write_length(7'd1);
    push_segment(2);
    drain();

    // random phases; store-full segments in two of them
    write_length(7'd64);
    random_phase(PHASE_ITEMS, 1'b1);
    drain();
    write_length(7'd3);
    push_segment(MAX_SEG);
    random_phase(PHASE_ITEMS, 1'b0);
    drain();
    write_length(7'd65);
    push_segment(2);
    random_phase(PHASE_ITEMS, 1'b0);
    // long receiver hold while words keep coming
    hold_request = LONG_HOLD;
    drain();
    write_length(7'd2);
    random_phase(PHASE_ITEMS, 1'b0);
    drain();
    write_length(7'd33);
    random_phase(PHASE_ITEMS, 1'b1);
    drain();
    write_length(7'd127);
    random_phase(PHASE_ITEMS, 1'b0);
    drain();
    write_length(7'd17);
    random_phase(PHASE_ITEMS, 1'b0);
    drain();
    write_length(7'($urandom_range(2, MAX_SEG)));
    random_phase(PHASE_ITEMS, 1'b0);
    drain();
    write_length(7'($urandom_range(0, 127)));
    random_phase(PHASE_ITEMS, 1'b0);
    drain();
    write_length(7'd64);
    random_phase(PHASE_ITEMS, 1'b0);

    while (sample_queue.size() > 0 || s_tvalid || resampled_q.size() > 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0 && resampled_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
